@@ rtl/core/slbsm_pkg.sv @@
// Shared types and constants for the serial-loaded bank switch mapper.
// No dependencies; imported by every module of the block.
package slbsm_pkg;

    localparam int CMD_W     = 2;
    localparam int ADDR_W    = 16;
    localparam int DATA_W    = 8;
    localparam int MAP_W     = 19;
    localparam int PRGC_W    = 6;
    localparam int CHRS_W    = 5;
    localparam int SHIFT_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 6;

    // command codes
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PRG   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHR   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_BANK_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_SIZE_8K    = 2'd1;

    localparam int DATA_RESET_BIT = 7;

    localparam logic [SHIFT_W-1:0] CONTROL_RESET    = 5'h1C;
    localparam logic [SHIFT_W-1:0] CONTROL_RESET_OR = 5'h0C;
    localparam logic [PRGC_W-1:0]  PRG_COUNT_RESET  = 6'd16;
    localparam logic [CHRS_W-1:0]  CHR_SIZE_RESET   = 5'd16;
    localparam logic [2:0]         PRG_WIDE_RESET   = 3'd3;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_RESET,
        OP_SHIFT,
        OP_PRG,
        OP_CHR
    } t_op;

    // classified request as it sits in the queue
    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] address;
        logic              shift_bit;
    } t_qent;

    // status of the bank reduction unit
    typedef struct packed {
        logic               busy;
        logic               done;
        logic [PRGC_W-1:0]  rem;
    } t_rem_stat;

endpackage

@@ rtl/core/slbsm_front.sv @@
// Front end: accepts requests, classifies them and queues them.
// Depends on slbsm_pkg.
module slbsm_front import slbsm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_ent_valid,
    output t_qent             o_ent,
    input  logic              i_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_qent              r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    t_qent              w_ent;
    logic               w_push;
    logic               w_pop;

    always_comb begin
        w_ent.address   = i_address;
        w_ent.shift_bit = i_data[0];
        case (i_cmd)
            CMD_WRITE: w_ent.op = i_data[DATA_RESET_BIT] ? OP_RESET : OP_SHIFT;
            CMD_PRG:   w_ent.op = OP_PRG;
            CMD_CHR:   w_ent.op = OP_CHR;
            default:   w_ent.op = OP_NONE;
        endcase
    end

    assign o_ready     = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_ent_valid = (r_count != '0);
    assign o_ent       = r_q[r_rd_ptr];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = i_pop && o_ent_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_ent;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/core/slbsm_rem.sv @@
// Bank reduction unit: remainder of a bank number by the CHR size,
// one restoring step per cycle. Depends on slbsm_pkg.
module slbsm_rem import slbsm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [SHIFT_W-1:0] i_dividend,
    input  logic [PRGC_W-1:0]  i_divisor,
    output t_rem_stat          o_stat
);

    localparam int STEP_W = $clog2(SHIFT_W);

    logic               r_busy;
    logic               r_done;
    logic [STEP_W-1:0]  r_step;
    logic [PRGC_W-1:0]  r_rem;
    logic [SHIFT_W-1:0] r_dvd;
    logic [PRGC_W-1:0]  r_div;
    logic [PRGC_W:0]    w_trial;
    logic [PRGC_W:0]    w_diff;
    logic               w_ge;

    assign w_trial = {r_rem, r_dvd[SHIFT_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[PRGC_W-1:0] : w_trial[PRGC_W-1:0];
            r_dvd <= {r_dvd[SHIFT_W-2:0], 1'b0};
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == STEP_W'(SHIFT_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_div))
        else $error("remainder not below divisor");
    a_busy_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done))
        else $error("busy and done together");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_busy && !r_done))
        else $error("start did not begin reduction");
`endif

endmodule

@@ rtl/core/slbsm_back.sv @@
// Back end: mapper registers, serial load, address translation and the
// result register. Depends on slbsm_pkg and drives slbsm_rem.
module slbsm_back import slbsm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_ent_valid,
    input  t_qent                i_ent,
    output logic                 o_pop,
    output logic                 o_rem_start,
    output logic [SHIFT_W-1:0]   o_rem_dividend,
    output logic [PRGC_W-1:0]    o_rem_divisor,
    input  t_rem_stat            i_rem_stat,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [MAP_W-1:0]     o_mapped_address,
    output logic                 o_chr_ram,
    output logic [1:0]           o_mirror_mode
);

    typedef enum logic {S_RUN, S_REDUCE} t_state;
    typedef enum logic [1:0] {DST_WIDE, DST_LOW, DST_HIGH} t_dst;

    localparam logic [1:0] TGT_CONTROL = 2'd0;
    localparam logic [1:0] TGT_CHR0    = 2'd1;
    localparam logic [1:0] TGT_CHR1    = 2'd2;
    localparam logic [1:0] TGT_PRG     = 2'd3;

    t_state             r_state,   n_state;
    t_dst               r_dst,     n_dst;
    logic [PRGC_W-1:0]  r_prg_bank_count, n_prg_bank_count;
    logic [CHRS_W-1:0]  r_chr_size_8k,    n_chr_size_8k;
    logic [SHIFT_W-1:0] r_shift_value,    n_shift_value;
    logic [2:0]         r_shift_count,    n_shift_count;
    logic [4:0]         r_control,        n_control;
    logic [2:0]         r_prg_bank_wide,  n_prg_bank_wide;
    logic [3:0]         r_prg_bank_low_half,  n_prg_bank_low_half;
    logic [4:0]         r_prg_bank_high_half, n_prg_bank_high_half;
    logic [3:0]         r_chr_bank_wide,      n_chr_bank_wide;
    logic [4:0]         r_chr_bank_low_half,  n_chr_bank_low_half;
    logic [4:0]         r_chr_bank_high_half, n_chr_bank_high_half;
    logic               r_out_valid,  n_out_valid;
    logic [MAP_W-1:0]   r_out_mapped, n_out_mapped;
    logic               r_out_ram,    n_out_ram;
    logic [1:0]         r_out_mirror, n_out_mirror;

    logic               w_out_free;
    logic               w_emit;
    logic [PRGC_W-1:0]  w_count_m1;
    logic [PRGC_W-1:0]  w_cfg_m1;
    logic [SHIFT_W-1:0] w_sv;
    logic [4:0]         w_bank;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_count_m1 = r_prg_bank_count - 1'b1;
    assign w_cfg_m1   = i_cfg_data - 1'b1;
    assign w_sv       = {i_ent.shift_bit, r_shift_value[SHIFT_W-1:1]};

    always_comb begin
        n_state              = r_state;
        n_dst                = r_dst;
        n_prg_bank_count     = r_prg_bank_count;
        n_chr_size_8k        = r_chr_size_8k;
        n_shift_value        = r_shift_value;
        n_shift_count        = r_shift_count;
        n_control            = r_control;
        n_prg_bank_wide      = r_prg_bank_wide;
        n_prg_bank_low_half  = r_prg_bank_low_half;
        n_prg_bank_high_half = r_prg_bank_high_half;
        n_chr_bank_wide      = r_chr_bank_wide;
        n_chr_bank_low_half  = r_chr_bank_low_half;
        n_chr_bank_high_half = r_chr_bank_high_half;
        n_out_mapped         = r_out_mapped;
        n_out_ram            = r_out_ram;
        o_pop                = 1'b0;
        o_rem_start          = 1'b0;
        o_rem_dividend       = w_sv;
        o_rem_divisor        = {r_chr_size_8k, 1'b0};
        w_emit               = 1'b0;
        w_bank               = '0;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PRG_BANK_COUNT: begin
                    n_prg_bank_count     = i_cfg_data;
                    n_prg_bank_high_half = w_cfg_m1[4:0];
                end
                CFG_CHR_SIZE_8K: n_chr_size_8k = i_cfg_data[CHRS_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            S_RUN: begin
                if (i_ent_valid && w_out_free) begin
                    o_pop        = 1'b1;
                    w_emit       = 1'b1;
                    n_out_mapped = '0;
                    n_out_ram    = 1'b0;
                    case (i_ent.op)
                        OP_RESET: begin
                            n_shift_value        = '0;
                            n_shift_count        = '0;
                            n_control            = r_control | CONTROL_RESET_OR;
                            n_prg_bank_high_half = w_count_m1[4:0];
                        end
                        OP_SHIFT: begin
                            if (r_shift_count == 3'(SHIFT_W - 1)) begin
                                n_shift_value = '0;
                                n_shift_count = '0;
                                case (i_ent.address[14:13])
                                    TGT_CONTROL: n_control = w_sv;
                                    TGT_CHR0: begin
                                        if (r_chr_size_8k != '0) begin
                                            // bank reduced modulo CHR size first
                                            o_rem_start = 1'b1;
                                            w_emit      = 1'b0;
                                            n_state     = S_REDUCE;
                                            if (r_control[4]) begin
                                                n_dst = DST_LOW;
                                            end else begin
                                                n_dst          = DST_WIDE;
                                                o_rem_dividend = {1'b0, w_sv[4:1]};
                                                o_rem_divisor  = {1'b0, r_chr_size_8k};
                                            end
                                        end else if (r_control[4]) begin
                                            n_chr_bank_low_half = w_sv;
                                        end else begin
                                            n_chr_bank_wide = w_sv[4:1];
                                        end
                                    end
                                    TGT_CHR1: begin
                                        if (r_control[4]) begin
                                            if (r_chr_size_8k != '0) begin
                                                o_rem_start = 1'b1;
                                                w_emit      = 1'b0;
                                                n_state     = S_REDUCE;
                                                n_dst       = DST_HIGH;
                                            end else begin
                                                n_chr_bank_high_half = w_sv;
                                            end
                                        end
                                    end
                                    TGT_PRG: begin
                                        case (r_control[3:2])
                                            2'd2: begin
                                                n_prg_bank_low_half  = '0;
                                                n_prg_bank_high_half = {1'b0, w_sv[3:0]};
                                            end
                                            2'd3: begin
                                                n_prg_bank_low_half  = w_sv[3:0];
                                                n_prg_bank_high_half = w_count_m1[4:0];
                                            end
                                            default: n_prg_bank_wide = w_sv[3:1];
                                        endcase
                                    end
                                    default: ;
                                endcase
                            end else begin
                                n_shift_value = w_sv;
                                n_shift_count = r_shift_count + 1'b1;
                            end
                        end
                        OP_PRG: begin
                            if (r_control[3]) begin
                                w_bank = i_ent.address[14] ? r_prg_bank_high_half
                                                           : {1'b0, r_prg_bank_low_half};
                                n_out_mapped = {w_bank, i_ent.address[13:0]};
                            end else begin
                                n_out_mapped = {1'b0, r_prg_bank_wide, i_ent.address[14:0]};
                            end
                        end
                        OP_CHR: begin
                            if (r_chr_size_8k == '0) begin
                                n_out_mapped = {3'b000, i_ent.address};
                                n_out_ram    = 1'b1;
                            end else if (r_control[4]) begin
                                w_bank = i_ent.address[12] ? r_chr_bank_high_half
                                                           : r_chr_bank_low_half;
                                n_out_mapped = {2'b00, w_bank, i_ent.address[11:0]};
                            end else begin
                                n_out_mapped = {2'b00, r_chr_bank_wide, i_ent.address[12:0]};
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_REDUCE: begin
                if (i_rem_stat.done && w_out_free) begin
                    w_emit       = 1'b1;
                    n_out_mapped = '0;
                    n_out_ram    = 1'b0;
                    n_state      = S_RUN;
                    case (r_dst)
                        DST_WIDE: n_chr_bank_wide      = i_rem_stat.rem[3:0];
                        DST_LOW:  n_chr_bank_low_half  = i_rem_stat.rem[4:0];
                        DST_HIGH: n_chr_bank_high_half = i_rem_stat.rem[4:0];
                        default:  ;
                    endcase
                end
            end
            default: n_state = S_RUN;
        endcase

        n_out_valid  = w_emit || (r_out_valid && !i_out_ready);
        n_out_mirror = w_emit ? n_control[1:0] : r_out_mirror;
    end

    always_ff @(posedge i_clk) begin
        r_dst        <= n_dst;
        r_out_mapped <= n_out_mapped;
        r_out_ram    <= n_out_ram;
        r_out_mirror <= n_out_mirror;
        if (!i_rst_n) begin
            r_state              <= S_RUN;
            r_prg_bank_count     <= PRG_COUNT_RESET;
            r_chr_size_8k        <= CHR_SIZE_RESET;
            r_shift_value        <= '0;
            r_shift_count        <= '0;
            r_control            <= CONTROL_RESET;
            r_prg_bank_wide      <= PRG_WIDE_RESET;
            r_prg_bank_low_half  <= '0;
            r_prg_bank_high_half <= 5'(PRG_COUNT_RESET - 1'b1);
            r_chr_bank_wide      <= '0;
            r_chr_bank_low_half  <= '0;
            r_chr_bank_high_half <= '0;
            r_out_valid          <= 1'b0;
        end else begin
            r_state              <= n_state;
            r_prg_bank_count     <= n_prg_bank_count;
            r_chr_size_8k        <= n_chr_size_8k;
            r_shift_value        <= n_shift_value;
            r_shift_count        <= n_shift_count;
            r_control            <= n_control;
            r_prg_bank_wide      <= n_prg_bank_wide;
            r_prg_bank_low_half  <= n_prg_bank_low_half;
            r_prg_bank_high_half <= n_prg_bank_high_half;
            r_chr_bank_wide      <= n_chr_bank_wide;
            r_chr_bank_low_half  <= n_chr_bank_low_half;
            r_chr_bank_high_half <= n_chr_bank_high_half;
            r_out_valid          <= n_out_valid;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_mapped_address = r_out_mapped;
    assign o_chr_ram        = r_out_ram;
    assign o_mirror_mode    = r_out_mirror;

`ifndef SYNTHESIS
    a_shift_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shift_count < 3'(SHIFT_W))
        else $error("shift count past load point");
    a_reduce_has_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REDUCE) |-> (i_rem_stat.busy || i_rem_stat.done))
        else $error("waiting on idle reduction unit");
    a_no_pop_in_reduce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REDUCE) |-> !o_pop)
        else $error("request popped during reduction");
    a_start_enters_reduce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rem_start |=> (r_state == S_REDUCE))
        else $error("reduction started without wait state");
`endif

endmodule

@@ rtl/core/serial_loaded_bank_switch_mapper.sv @@
// Top level of the serial-loaded bank switch mapper.
// Depends on slbsm_pkg, slbsm_front, slbsm_rem and slbsm_back.
//
// Usage:
//   Request channel (i_in_valid/o_in_ready): cmd 0 is a register write
//   (data bit 7 resets the serial loader, else data bit 0 is shifted in),
//   cmd 1 translates a PRG read address, cmd 2 a CHR read address.
//   Result channel (o_out_valid/i_out_ready): one result per request, in
//   order: ROM offset, CHR RAM flag and the current mirroring mode.
//   Config channel (i_cfg_valid/o_cfg_ready): always ready; index 0 is the
//   PRG bank count, index 1 the CHR size in 8 KB units. Write only while idle.
// Flow:
//   A request lands in a two-entry queue, from which the back end takes it
//   into the result register. One request per cycle is sustained while the
//   receiver is ready and no reduction runs. A fifth serial write that loads
//   a CHR bank with CHR ROM present runs the bank through a bit-serial
//   remainder unit, 5 steps, and holds the back end until it is done.
// Reset (synchronous, active low) restores the power-on banks and mode.
// When the receiver stalls, the result register holds, the queue fills
// and o_in_ready drops after two further requests.
module serial_loaded_bank_switch_mapper import slbsm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic [ADDR_W-1:0]    i_address,
    input  logic [DATA_W-1:0]    i_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [MAP_W-1:0]     o_mapped_address,
    output logic                 o_chr_ram,
    output logic [1:0]           o_mirror_mode,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    logic               w_ent_valid;
    t_qent              w_ent;
    logic               w_pop;
    logic               w_rem_start;
    logic [SHIFT_W-1:0] w_rem_dividend;
    logic [PRGC_W-1:0]  w_rem_divisor;
    t_rem_stat          w_rem_stat;

    // config registers live in flops and are taken every cycle
    assign o_cfg_ready = 1'b1;

    slbsm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_cmd       (i_cmd),
        .i_address   (i_address),
        .i_data      (i_data),
        .o_ent_valid (w_ent_valid),
        .o_ent       (w_ent),
        .i_pop       (w_pop)
    );

    slbsm_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rem_start),
        .i_dividend (w_rem_dividend),
        .i_divisor  (w_rem_divisor),
        .o_stat     (w_rem_stat)
    );

    slbsm_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_ent_valid      (w_ent_valid),
        .i_ent            (w_ent),
        .o_pop            (w_pop),
        .o_rem_start      (w_rem_start),
        .o_rem_dividend   (w_rem_dividend),
        .o_rem_divisor    (w_rem_divisor),
        .i_rem_stat       (w_rem_stat),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_mapped_address (o_mapped_address),
        .o_chr_ram        (o_chr_ram),
        .o_mirror_mode    (o_mirror_mode)
    );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for serial_loaded_bank_switch_mapper: directed and random requests,
// checked against a bank-switching model that the bench keeps beside the block.
// Depends on slbsm_pkg and the mapper RTL only.
module tb_top;
    import slbsm_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 10;
    localparam int STALL_LIMIT   = 1000;   // cycles with no handshake on any channel
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_PRINTED   = 100;
    localparam int IDLE_PCT      = 22;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 250;
    localparam int DIRECTED_CNT  = 23;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // write target, address bits 14:13
    localparam logic [1:0] TGT_CONTROL = 2'd0;
    localparam logic [1:0] TGT_CHR0    = 2'd1;
    localparam logic [1:0] TGT_CHR1    = 2'd2;
    localparam logic [1:0] TGT_PRG     = 2'd3;

    // PRG mode, control bits 3:2 (0 and 1 both mean 32 KB switching)
    localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
    localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

    localparam int CTRL_PRG_16K = 3;
    localparam int CTRL_CHR_4K  = 4;

    typedef struct packed {
        logic              drain_first;   // hold back until every result is home
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
    } t_bus_req;

    typedef struct packed {
        logic [MAP_W-1:0] mapped_address;
        logic             chr_ram;
        logic [1:0]       mirror_mode;
    } t_map_res;

    // DUT inputs, known from time zero
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic [CMD_W-1:0]     i_cmd       = '0;
    logic [ADDR_W-1:0]    i_address   = '0;
    logic [DATA_W-1:0]    i_data      = '0;
    logic                 i_out_ready = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data  = '0;

    logic             o_in_ready;
    logic             o_out_valid;
    logic [MAP_W-1:0] o_mapped_address;
    logic             o_chr_ram;
    logic [1:0]       o_mirror_mode;
    logic             o_cfg_ready;

    t_bus_req pending_reqs[$];
    t_map_res expected_xlat[$];

    int   mismatches   = 0;
    int   idle_pct     = IDLE_PCT;
    int   quiet_cycles = 0;
    logic drain_next   = 1'b0;

    // mapper state as the bench sees it
    logic [PRGC_W-1:0]  m_prg_count;
    logic [CHRS_W-1:0]  m_chr_size;
    logic [SHIFT_W-1:0] m_shift;
    logic [2:0]         m_shift_cnt;
    logic [4:0]         m_control;
    logic [2:0]         m_prg_wide;
    logic [3:0]         m_prg_lo;
    logic [4:0]         m_prg_hi;
    logic [3:0]         m_chr_wide;
    logic [4:0]         m_chr_lo;
    logic [4:0]         m_chr_hi;

    always #(CLK_HALF) i_clk = ~i_clk;

    serial_loaded_bank_switch_mapper dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cmd            (i_cmd),
        .i_address        (i_address),
        .i_data           (i_data),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_mapped_address (o_mapped_address),
        .o_chr_ram        (o_chr_ram),
        .o_mirror_mode    (o_mirror_mode),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Bank-switching model
    // ------------------------------------------------------------------

    // last 16 KB bank, wraps to 31 for a count of zero
    function automatic logic [4:0] last_prg_bank();
        logic [PRGC_W-1:0] last;
        last = m_prg_count - 1'b1;
        return last[4:0];
    endfunction

    // CHR bank reduced modulo the ROM size in bank units; no CHR ROM leaves it alone
    function automatic logic [4:0] reduce_bank(logic [4:0] bank, logic [5:0] units);
        if (units == '0)
            return bank;
        return 5'(bank % units);
    endfunction

    function automatic void reset_model();
        m_prg_count = PRG_COUNT_RESET;
        m_chr_size  = CHR_SIZE_RESET;
        m_shift     = '0;
        m_shift_cnt = '0;
        m_control   = CONTROL_RESET;
        m_prg_wide  = PRG_WIDE_RESET;
        m_prg_lo    = '0;
        m_prg_hi    = last_prg_bank();
        m_chr_wide  = '0;
        m_chr_lo    = '0;
        m_chr_hi    = '0;
    endfunction

    function automatic void apply_config(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DAT_W-1:0] val);
        case (idx)
            CFG_PRG_BANK_COUNT: begin
                m_prg_count = val[PRGC_W-1:0];
                m_prg_hi    = last_prg_bank();
            end
            CFG_CHR_SIZE_8K: m_chr_size = val[CHRS_W-1:0];
            default: ;
        endcase
    endfunction

    // fifth serial bit: the mode in force now decides how the bank is stored
    function automatic void load_bank(logic [ADDR_W-1:0] addr, logic [SHIFT_W-1:0] val);
        logic [4:0] red;
        case (addr[14:13])
            TGT_CONTROL: m_control = val;
            TGT_CHR0: begin
                if (!m_control[CTRL_CHR_4K]) begin
                    red        = reduce_bank({1'b0, val[4:1]}, {1'b0, m_chr_size});
                    m_chr_wide = red[3:0];
                end else begin
                    m_chr_lo = reduce_bank(val, {m_chr_size, 1'b0});
                end
            end
            TGT_CHR1: begin
                // ignored in 8 KB mode
                if (m_control[CTRL_CHR_4K])
                    m_chr_hi = reduce_bank(val, {m_chr_size, 1'b0});
            end
            TGT_PRG: begin
                case (m_control[3:2])
                    PRG_MODE_FIX_FIRST: begin
                        m_prg_lo = '0;
                        m_prg_hi = {1'b0, val[3:0]};
                    end
                    PRG_MODE_FIX_LAST: begin
                        m_prg_lo = val[3:0];
                        m_prg_hi = last_prg_bank();
                    end
                    default: m_prg_wide = val[3:1];
                endcase
            end
            default: ;
        endcase
    endfunction

    // advance the model by one accepted request and queue the translation it gives
    function automatic void map_request(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                                        logic [DATA_W-1:0] data);
        t_map_res   res;
        logic [4:0] bank;
        res = '0;
        case (cmd)
            CMD_WRITE: begin
                if (data[DATA_RESET_BIT]) begin
                    // serial reset also forces 16 KB mode with the last bank fixed high
                    m_shift     = '0;
                    m_shift_cnt = '0;
                    m_control   = m_control | CONTROL_RESET_OR;
                    m_prg_hi    = last_prg_bank();
                end else begin
                    m_shift_cnt = m_shift_cnt + 1'b1;
                    m_shift     = {data[0], m_shift[SHIFT_W-1:1]};
                    if (m_shift_cnt == 3'd5) begin
                        load_bank(addr, m_shift);
                        m_shift     = '0;
                        m_shift_cnt = '0;
                    end
                end
            end
            CMD_PRG: begin
                if (m_control[CTRL_PRG_16K]) begin
                    bank               = addr[14] ? m_prg_hi : {1'b0, m_prg_lo};
                    res.mapped_address = {bank, addr[13:0]};
                end else begin
                    res.mapped_address = {1'b0, m_prg_wide, addr[14:0]};
                end
            end
            CMD_CHR: begin
                if (m_chr_size == '0) begin
                    res.mapped_address = {3'b000, addr};
                    res.chr_ram        = 1'b1;
                end else if (m_control[CTRL_CHR_4K]) begin
                    bank               = addr[12] ? m_chr_hi : m_chr_lo;
                    res.mapped_address = {2'b00, bank, addr[11:0]};
                end else begin
                    res.mapped_address = {2'b00, m_chr_wide, addr[12:0]};
                end
            end
            default: ;   // unknown command leaves the state alone
        endcase
        res.mirror_mode = m_control[1:0];
        expected_xlat.push_back(res);
    endfunction

    // ------------------------------------------------------------------
    // Request generation
    // ------------------------------------------------------------------

    function automatic void push_req(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                                     logic [DATA_W-1:0] data);
        t_bus_req r;
        r.drain_first = drain_next;
        r.cmd         = cmd;
        r.address     = addr;
        r.data        = data;
        drain_next    = 1'b0;
        pending_reqs.push_back(r);
    endfunction

    // mostly in-window addresses, now and then anything at all
    function automatic void push_read();
        logic [ADDR_W-1:0] a;
        a = ADDR_W'($urandom_range(0, 16'hFFFF));
        if ($urandom_range(0, 1)) begin
            if ($urandom_range(0, 3) != 0)
                a[15] = 1'b1;
            push_req(CMD_PRG, a, DATA_W'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 3) != 0)
                a[15:13] = 3'b000;
            push_req(CMD_CHR, a, DATA_W'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void push_shift();
        push_req(CMD_WRITE, ADDR_W'($urandom_range(0, 16'hFFFF)),
                 DATA_W'($urandom_range(0, 127)));
    endfunction

    task automatic add_directed();
        push_req(CMD_PRG, 16'h8000, 8'h00);       // power-on: 16 KB, last bank high
        push_req(CMD_PRG, 16'hFFFF, 8'hFF);
        push_req(CMD_CHR, 16'h0000, 8'h00);       // power-on: 4 KB CHR
        push_req(CMD_CHR, 16'hFFFF, 8'hFF);
        push_req(CMD_UNUSED, 16'hFFFF, 8'hFF);
        push_req(CMD_WRITE, 16'h0000, 8'h80);     // serial reset
        // control <= 0x03: horizontal, 32 KB PRG, 8 KB CHR; junk in the upper data bits
        push_req(CMD_WRITE, 16'h9FFF, 8'h7F);
        push_req(CMD_WRITE, 16'h9FFF, 8'h01);
        push_req(CMD_WRITE, 16'h9FFF, 8'h7E);
        push_req(CMD_WRITE, 16'h9FFF, 8'h00);
        push_req(CMD_WRITE, 16'h9FFF, 8'h00);
        push_req(CMD_PRG, 16'hC123, 8'h00);
        // PRG bank 0x1F through an address below 0x8000
        repeat (5) push_req(CMD_WRITE, 16'h7FFF, 8'h01);
        push_req(CMD_PRG, 16'hFFFF, 8'h00);
        // reset in the middle of a load
        push_req(CMD_WRITE, 16'hC000, 8'h01);
        push_req(CMD_WRITE, 16'hFFFF, 8'hFF);
        push_req(CMD_PRG, 16'h4000, 8'h00);
        push_req(CMD_CHR, 16'h1FFF, 8'h00);
        push_req(CMD_UNUSED, 16'h0000, 8'h00);
    endtask

    // mostly complete five-write loads followed by reads; some partial
    // loads cut off by a serial reset, and a little raw noise
    task automatic add_random(int n);
        int added;
        int pick;
        int k;
        bit marked;
        added  = 0;
        marked = 1'b0;
        while (added < n) begin
            if (!marked && added >= n / 2) begin
                drain_next = 1'b1;
                marked     = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                repeat (5) push_shift();
                k = $urandom_range(1, 3);
                repeat (k) push_read();
                added += 5 + k;
            end else if (pick < 80) begin
                k = $urandom_range(1, 4);
                repeat (k) push_read();
                added += k;
            end else if (pick < 92) begin
                k = $urandom_range(1, 4);
                repeat (k) push_shift();
                push_req(CMD_WRITE, ADDR_W'($urandom_range(0, 16'hFFFF)),
                         DATA_W'($urandom_range(128, 255)));
                added += k + 1;
            end else begin
                push_req(CMD_W'($urandom_range(0, 3)), ADDR_W'($urandom_range(0, 16'hFFFF)),
                         DATA_W'($urandom_range(0, 255)));
                added++;
            end
        end
    endtask

    // sampled on the falling edge so nothing launched at the rising edge is missed
    task automatic wait_quiet();
        do
            @(negedge i_clk);
        while (pending_reqs.size() != 0 || i_in_valid || expected_xlat.size() != 0);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic report_mismatch(string what);
        if (mismatches < MAX_PRINTED)
            $display("%0t ns mismatch: %s", $time, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Request driver; also keeps the model in step with every handshake
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_requests
        logic     launch;
        t_bus_req nxt;
        if (!i_rst_n) begin
            reset_model();
            i_in_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                apply_config(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready)
                map_request(i_cmd, i_address, i_data);
            // a held request stays put until it is taken
            if (!i_in_valid || o_in_ready) begin
                launch = pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct;
                if (launch && pending_reqs[0].drain_first && expected_xlat.size() != 0)
                    launch = 1'b0;
                if (launch) begin
                    nxt        = pending_reqs.pop_front();
                    i_in_valid <= 1'b1;
                    i_cmd      <= nxt.cmd;
                    i_address  <= nxt.address;
                    i_data     <= nxt.data;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor with random back-pressure
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_map_res want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_xlat.size() == 0) begin
                    report_mismatch($sformatf("unexpected result mapped %h",
                                              o_mapped_address));
                end else begin
                    want = expected_xlat.pop_front();
                    if (o_mapped_address !== want.mapped_address ||
                        o_chr_ram !== want.chr_ram ||
                        o_mirror_mode !== want.mirror_mode)
                        report_mismatch($sformatf(
                            "mapped %h want %h, chr_ram %b want %b, mirror %0d want %0d",
                            o_mapped_address, want.mapped_address, o_chr_ram,
                            want.chr_ram, o_mirror_mode, want.mirror_mode));
                end
            end
            i_out_ready <= $urandom_range(0, 99) >= idle_pct;
        end
    end

    // nothing moving on any channel for too long means the block is stuck
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                     (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Phases: power-on settings first, then a configuration per phase
    // (bank count extremes, zero, CHR RAM, odd CHR sizes, one random pick)
    // ------------------------------------------------------------------
    initial begin : run_phases
        int prg_cfg[PHASES];
        int chr_cfg[PHASES];
        int ph;
        prg_cfg = '{16, 32, 1, 0, 7, 0, 16};
        chr_cfg = '{16, 16, 0, 1, 3, 0, 8};
        prg_cfg[5] = $urandom_range(1, 32);
        chr_cfg[5] = $urandom_range(0, 16);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (ph = 0; ph < PHASES; ph++) begin
            if (ph != 0) begin
                wait_quiet();
                write_cfg(CFG_PRG_BANK_COUNT, CFG_DAT_W'(prg_cfg[ph]));
                write_cfg(CFG_CHR_SIZE_8K, CFG_DAT_W'(chr_cfg[ph]));
            end
            // one phase runs flat out on both sides
            idle_pct = (ph == 1) ? 0 : IDLE_PCT;
            if (ph == 0) begin
                add_directed();
                add_random(PHASE_ITEMS - DIRECTED_CNT);
            end else begin
                add_random(PHASE_ITEMS);
            end
        end

        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_xlat.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
